// ----- hw/rtl/coalesced_hash_map_assert.svh -----
// Assertion macros for the coalesced hash map.
`ifndef COALESCED_HASH_MAP_ASSERT_SVH
`define COALESCED_HASH_MAP_ASSERT_SVH
`ifndef SYNTHESIS
`define CHM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CHM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CHM_ASSERT(lbl, prop, msg)
`define CHM_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- hw/rtl/chm_pkg.sv -----
// Shared types and constants of the coalesced hash map.
package chm_pkg;

  localparam int unsigned TableSizeDef = 256;
  localparam int unsigned KeyW         = 16;
  localparam int unsigned ValW         = 31;

  typedef enum logic [1:0] {
    ACT_SEARCH = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_ERASE  = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_MISS = 2'd1,
    STS_FULL = 2'd2
  } sts_e;

  typedef struct packed {
    logic [1:0]      action;
    logic [KeyW-1:0] lookup_key;
    logic [ValW-1:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [ValW-1:0] found_value;
    logic [1:0]      status;
  } rsp_t;

endpackage

// ----- hw/rtl/chm_ram.sv -----
// Generic simple dual-port RAM with registered read.
module chm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/chm_ctrl.sv -----
// Chain walker, probe sequencer and clearing pass of the coalesced hash map.
module chm_ctrl import chm_pkg::*; #(
  parameter int unsigned TableSize = TableSizeDef,
  localparam int unsigned IdxW  = $clog2(TableSize),
  localparam int unsigned SlotW = KeyW + ValW + IdxW + 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  req_t             in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rsp_t             out_data_o,
  output logic             mem_we_o,
  output logic [IdxW-1:0]  mem_waddr_o,
  output logic [SlotW-1:0] mem_wdata_o,
  output logic             mem_re_o,
  output logic [IdxW-1:0]  mem_raddr_o,
  input  logic [SlotW-1:0] mem_rdata_i
);

`include "coalesced_hash_map_assert.svh"

  typedef struct packed {
    logic            used;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
    logic            link_none;
    logic [IdxW-1:0] link;
  } slot_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_WALK  = 5'b00100,
    S_PROBE = 5'b01000,
    S_LINK  = 5'b10000
  } state_e;

  localparam logic [IdxW-1:0] IdxMax = {IdxW{1'b1}};

  state_e          state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] addr_q, addr_d;
  logic [IdxW-1:0] tail_addr_q, tail_addr_d;
  slot_t           tail_q, tail_d;
  logic [1:0]      op_q, op_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [ValW-1:0] val_q, val_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_q, out_d;

  slot_t           rd;
  slot_t           wr;
  logic            accept;
  logic            act_known;
  logic            hit;
  logic            last;

  assign rd        = slot_t'(mem_rdata_i);
  assign accept    = in_valid_i && in_ready_o;
  assign act_known = (in_data_i.action == ACT_SEARCH) || (in_data_i.action == ACT_INSERT) ||
                     (in_data_i.action == ACT_ERASE);
  assign hit       = rd.used && (rd.key == key_q);
  assign last      = rd.link_none || (cnt_q == IdxMax);

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign mem_wdata_o = SlotW'(wr);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    addr_d      = addr_q;
    tail_addr_d = tail_addr_q;
    tail_d      = tail_q;
    op_d        = op_q;
    key_d       = key_q;
    val_d       = val_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = addr_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = addr_q;
    wr          = rd;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        mem_we_o     = 1'b1;
        mem_waddr_o  = cnt_q;
        wr           = '0;
        wr.link_none = 1'b1;
        wr.link      = IdxMax;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == IdxMax) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (act_known) begin
            op_d        = in_data_i.action;
            key_d       = in_data_i.lookup_key;
            val_d       = in_data_i.entry_value;
            addr_d      = in_data_i.lookup_key[IdxW-1:0];
            mem_re_o    = 1'b1;
            mem_raddr_o = in_data_i.lookup_key[IdxW-1:0];
            cnt_d       = '0;
            state_d     = S_WALK;
          end else begin
            out_valid_d       = 1'b1;
            out_d.found_value = '0;
            out_d.status      = STS_MISS;
          end
        end
      end
      S_WALK: begin
        out_d.found_value = '0;
        out_d.status      = STS_OK;
        if (op_q == ACT_INSERT) begin
          if (!rd.used) begin
            mem_we_o    = 1'b1;
            wr.used     = 1'b1;
            wr.key      = key_q;
            wr.value    = val_q;
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else if (last) begin
            tail_addr_d = addr_q;
            tail_d      = rd;
            addr_d      = IdxW'({addr_q, 1'b1});
            mem_re_o    = 1'b1;
            mem_raddr_o = IdxW'({addr_q, 1'b1});
            cnt_d       = '0;
            state_d     = S_PROBE;
          end else begin
            addr_d      = rd.link;
            mem_re_o    = 1'b1;
            mem_raddr_o = rd.link;
            cnt_d       = cnt_q + 1'b1;
          end
        end else begin
          if (hit) begin
            if (op_q == ACT_SEARCH) begin
              out_d.found_value = rd.value;
            end else begin
              mem_we_o = 1'b1;
              wr.used  = 1'b0;
            end
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else if (last) begin
            out_d.status = STS_MISS;
            out_valid_d  = 1'b1;
            state_d      = S_IDLE;
          end else begin
            addr_d      = rd.link;
            mem_re_o    = 1'b1;
            mem_raddr_o = rd.link;
            cnt_d       = cnt_q + 1'b1;
          end
        end
      end
      S_PROBE: begin
        if (!rd.used) begin
          mem_we_o = 1'b1;
          wr.used  = 1'b1;
          wr.key   = key_q;
          wr.value = val_q;
          state_d  = S_LINK;
        end else if (cnt_q == IdxMax) begin
          out_d.found_value = '0;
          out_d.status      = STS_FULL;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end else begin
          addr_d      = addr_q + 1'b1;
          mem_re_o    = 1'b1;
          mem_raddr_o = addr_q + 1'b1;
          cnt_d       = cnt_q + 1'b1;
        end
      end
      S_LINK: begin
        mem_we_o          = 1'b1;
        mem_waddr_o       = tail_addr_q;
        wr                = tail_q;
        wr.link_none      = 1'b0;
        wr.link           = addr_q;
        out_d.found_value = '0;
        out_d.status      = STS_OK;
        out_valid_d       = 1'b1;
        state_d           = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    tail_addr_q <= tail_addr_d;
    tail_q      <= tail_d;
    op_q        <= op_d;
    key_q       <= key_d;
    val_q       <= val_d;
    out_q       <= out_d;
  end

  `CHM_ASSERT_NEVER(a_rw_same_slot, mem_we_o && mem_re_o && (mem_waddr_o == mem_raddr_o), "read and write hit the same slot")
  `CHM_ASSERT(a_walk_after_accept, accept && act_known |=> state_q == S_WALK, "accepted item did not start a walk")
  `CHM_ASSERT(a_link_result, (state_q == S_LINK) |=> out_valid_q, "linked insert gave no result")
  `CHM_ASSERT_NEVER(a_link_to_tail, (state_q == S_LINK) && (addr_q == tail_addr_q), "tail linked to itself")
  `CHM_ASSERT_NEVER(a_clear_busy, (state_q == S_CLEAR) && in_ready_o, "item taken during clearing pass")

endmodule

// ----- hw/rtl/coalesced_hash_map.sv -----
// Coalesced chaining hash map: slot RAM and chain walker.
// Search and erase walk the chain from the home slot until a hit or the chain end. Insert
// fills the first free slot on the chain, or probes onward, links the tail or reports full.
// Unused action code: result in the cycle after accept, nothing changes.
// One item at a time, with one slot RAM read per hop; the next item
// is taken in the cycle after a result is loaded, if out_ready_i is high.
// Reset: a clearing pass writes every slot empty, and no item is taken during it.
module coalesced_hash_map import chm_pkg::*; #(
  parameter int unsigned TableSize = TableSizeDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  localparam int unsigned IdxW  = $clog2(TableSize);
  localparam int unsigned SlotW = KeyW + ValW + IdxW + 2;

  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic [SlotW-1:0] mem_wdata;
  logic             mem_re;
  logic [IdxW-1:0]  mem_raddr;
  logic [SlotW-1:0] mem_rdata;

  chm_ctrl #(
    .TableSize(TableSize)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o,
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  chm_ram #(
    .Width(SlotW),
    .Depth(TableSize)
  ) u_ram (
    .clk_i,
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
